@@ src/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Result types, status and tag codes, character constants and the table of
// known header names shared by the parser modules.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  typedef enum logic [1:0] {
    STATUS_NONE = 2'd0,
    STATUS_GOOD = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_URI       = 2'd1,
    KIND_VALUE     = 2'd2,
    KIND_VALUE_END = 2'd3
  } kind_e;

  typedef struct packed {
    status_e     status;
    kind_e       kind;
    logic [2:0]  header_id;
    logic [7:0]  data;
  } hrhp_res_t;

  localparam logic [2:0] HID_UNKNOWN = 3'd0;
  localparam int         NUM_NAMES   = 6;
  localparam logic [4:0] POS_MAX     = 5'd31;
  localparam logic [5:0] MASK_ALL    = 6'h3f;

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [4:0] NAME_LEN [NUM_NAMES] = '{5'd7, 5'd6, 5'd10, 5'd17, 5'd21, 5'd7};

  localparam logic [21*8-1:0] NAME_STR [NUM_NAMES] = '{
    168'("upgrade"),
    168'("origin"),
    168'("connection"),
    168'("sec-websocket-key"),
    168'("sec-websocket-version"),
    168'("cookies")
  };

  function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [4:0] pos);
    logic [4:0] len;
    logic [4:0] sel;
    logic [7:0] c;
    len = NAME_LEN[idx];
    sel = len - pos - 5'd1;
    c   = 8'h00;
    if (pos < len) begin
      c = NAME_STR[idx][{sel, 3'b000} +: 8];
    end
    return c;
  endfunction

  function automatic logic is_control(input logic [7:0] c);
    return (c <= 8'd31) || (c >= 8'd127);
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    logic sep;
    case (c) inside
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", CH_SP, CH_TAB: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return sep;
  endfunction

  function automatic logic [2:0] settle_header(input logic [5:0] mask, input logic [4:0] pos);
    logic [2:0] hid;
    hid = HID_UNKNOWN;
    for (int i = NUM_NAMES - 1; i >= 0; i--) begin
      if (mask[i] && (NAME_LEN[i] == pos)) begin
        hid = 3'(i + 1);
      end
    end
    return hid;
  endfunction

endpackage

@@ src/hrhp_fsm.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser state machine
// Holds the parse state and header name match, and works out the result of
// the current request byte; state advances when enabled.
// ----------------------------------------------------------------------------
module hrhp_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        byte_i,
  output hrhp_pkg::hrhp_res_t res_o
);
  import hrhp_pkg::*;

  typedef enum logic [4:0] {
    S_G        = 5'd0,
    S_E        = 5'd1,
    S_T        = 5'd2,
    S_SP       = 5'd3,
    S_URI      = 5'd4,
    S_VH       = 5'd5,
    S_VT1      = 5'd6,
    S_VT2      = 5'd7,
    S_VP       = 5'd8,
    S_VSLASH   = 5'd9,
    S_VMAJ     = 5'd10,
    S_VDOT     = 5'd11,
    S_VMIN     = 5'd12,
    S_VCR      = 5'd13,
    S_VLF      = 5'd14,
    S_HSTART   = 5'd15,
    S_HNAME    = 5'd16,
    S_HVSTART  = 5'd17,
    S_HVAL     = 5'd18,
    S_HLF      = 5'd19,
    S_FINAL_LF = 5'd20,
    S_AFTER    = 5'd21
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] mask_q, mask_d;
  logic [4:0] pos_q, pos_d;
  logic [2:0] hdr_q, hdr_d;

  logic       lit_sel;
  logic [7:0] lit_exp;
  state_e     lit_nxt;
  logic [7:0] lc;
  logic       ctrl;
  logic       name_ok;
  logic [5:0] mask_take;

  always_comb begin
    lit_sel = 1'b1;
    lit_exp = 8'h00;
    lit_nxt = state_q;
    unique case (state_q)
      S_G:      begin lit_exp = "G";   lit_nxt = S_E;      end
      S_E:      begin lit_exp = "E";   lit_nxt = S_T;      end
      S_T:      begin lit_exp = "T";   lit_nxt = S_SP;     end
      S_SP:     begin lit_exp = CH_SP; lit_nxt = S_URI;    end
      S_VH:     begin lit_exp = "H";   lit_nxt = S_VT1;    end
      S_VT1:    begin lit_exp = "T";   lit_nxt = S_VT2;    end
      S_VT2:    begin lit_exp = "T";   lit_nxt = S_VP;     end
      S_VP:     begin lit_exp = "P";   lit_nxt = S_VSLASH; end
      S_VSLASH: begin lit_exp = "/";   lit_nxt = S_VMAJ;   end
      S_VMAJ:   begin lit_exp = "1";   lit_nxt = S_VDOT;   end
      S_VDOT:   begin lit_exp = ".";   lit_nxt = S_VMIN;   end
      S_VMIN:   begin lit_exp = "1";   lit_nxt = S_VCR;    end
      S_VCR:    begin lit_exp = CH_CR; lit_nxt = S_VLF;    end
      S_VLF:    begin lit_exp = CH_LF; lit_nxt = S_HSTART; end
      default:  lit_sel = 1'b0;
    endcase
  end

  always_comb begin
    lc      = ((byte_i >= "A") && (byte_i <= "Z")) ? (byte_i + 8'd32) : byte_i;
    ctrl    = is_control(byte_i);
    name_ok = !ctrl && !is_separator(byte_i);
    for (int i = 0; i < NUM_NAMES; i++) begin
      mask_take[i] = mask_q[i] && (name_char(3'(i), pos_q) == lc);
    end
  end

  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    pos_d   = pos_q;
    hdr_d   = hdr_q;
    res_o   = '{status: STATUS_NONE, kind: KIND_NONE, header_id: HID_UNKNOWN, data: 8'h00};
    if (lit_sel) begin
      if (byte_i == lit_exp) begin
        state_d = lit_nxt;
      end else begin
        res_o.status = STATUS_BAD;
      end
    end else begin
      unique case (state_q)
        S_URI: begin
          if (byte_i == CH_SP) begin
            state_d = S_VH;
          end else if (!ctrl) begin
            res_o.kind = KIND_URI;
            res_o.data = byte_i;
          end else begin
            res_o.status = STATUS_BAD;
          end
        end
        S_HSTART, S_HNAME: begin
          if ((state_q == S_HSTART) && (byte_i == CH_CR)) begin
            state_d = S_FINAL_LF;
          end else if ((state_q == S_HNAME) && (byte_i == ":")) begin
            hdr_d   = settle_header(mask_q, pos_q);
            state_d = S_HVSTART;
          end else begin
            state_d = S_HNAME;
            if (name_ok) begin
              mask_d = mask_take;
              pos_d  = (pos_q == POS_MAX) ? pos_q : (pos_q + 5'd1);
            end else begin
              res_o.status = STATUS_BAD;
            end
          end
        end
        S_HVSTART, S_HVAL: begin
          if ((state_q == S_HVSTART) && ((byte_i == CH_SP) || (byte_i == CH_TAB))) begin
            state_d = state_q;
          end else if ((state_q == S_HVAL) && (byte_i == CH_CR)) begin
            res_o.kind      = KIND_VALUE_END;
            res_o.header_id = hdr_q;
            mask_d          = MASK_ALL;
            pos_d           = 5'd0;
            hdr_d           = HID_UNKNOWN;
            state_d         = S_HLF;
          end else begin
            state_d = S_HVAL;
            if (!ctrl) begin
              res_o.kind      = KIND_VALUE;
              res_o.header_id = hdr_q;
              res_o.data      = byte_i;
            end else begin
              res_o.status = STATUS_BAD;
            end
          end
        end
        S_HLF: begin
          if (byte_i == CH_LF) begin
            state_d = S_HSTART;
          end else begin
            res_o.status = STATUS_BAD;
          end
        end
        S_FINAL_LF: begin
          if (byte_i == CH_LF) begin
            state_d      = S_AFTER;
            res_o.status = STATUS_GOOD;
          end else begin
            res_o.status = STATUS_BAD;
          end
        end
        default: res_o.status = STATUS_BAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_G;
      mask_q  <= MASK_ALL;
      pos_q   <= 5'd0;
      hdr_q   <= HID_UNKNOWN;
    end else if (en_i) begin
      state_q <= state_d;
      mask_q  <= mask_d;
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
    end
  end

endmodule

@@ src/http_request_header_parser.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser
// Checks one HTTP/1.1 GET request byte by byte and streams out tagged URI
// and header value bytes.
//
// Input channel: in_valid_i / in_stall_o carry one request byte on
// byte_in_i. Output channel: out_valid_o / out_stall_i carry one result per
// byte: status_o, kind_o, header_id_o and data_out_o. A request moves at a
// clock edge where valid is high and stall is low.
// Each byte passes through an input register, then a result register,
// before its result is presented.
// Throughput: one byte per cycle while the receiver does not stall; the
// parse state updates from the registered byte.
// Reset clears both stages and returns the parser to the start of the
// method, with all header name candidates live.
// When the receiver stalls, the result register holds; the input register,
// if empty, takes one more byte, then in_stall_o rises until the result moves.
// ----------------------------------------------------------------------------
module http_request_header_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [1:0] kind_o,
  output logic [2:0] header_id_o,
  output logic [7:0] data_out_o
);
  import hrhp_pkg::*;

  logic      s1_valid_q, s1_valid_d;
  logic [7:0] byte_q;
  logic      out_valid_q;
  hrhp_res_t res_q;
  hrhp_res_t res;
  logic      advance;
  logic      in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign s1_valid_d = (advance || !s1_valid_q) ? in_valid_i : s1_valid_q;

  hrhp_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_valid_q && advance),
    .byte_i (byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= byte_in_i;
    end
    if (advance && s1_valid_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign kind_o      = res_q.kind;
  assign header_id_o = res_q.header_id;
  assign data_out_o  = res_q.data;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("input stalled without a blocked result");

  a_data_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((kind_o == KIND_URI) || (kind_o == KIND_VALUE)))
    |-> ((data_out_o >= 8'd32) && (data_out_o < 8'd127) && (status_o == STATUS_NONE)))
    else $error("streamed byte is a control byte or flagged");

  a_status_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_NONE))
    |-> ((kind_o == KIND_NONE) && (header_id_o == HID_UNKNOWN)))
    else $error("status reported together with a tagged byte");

  a_fill_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && in_stall_o) |=> s1_valid_q)
    else $error("held request byte lost");

endmodule
